// ===== design/assert_macros.svh =====
// Assertion macros for the RTL of the DTMF event parser.
// Depends on nothing; users must have clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define CHK_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);
`else
`define CHK_IMPLY(lbl, ante, cons, msg)
`define CHK_NEXT(lbl, ante, cons, msg)
`endif
`endif

// ===== design/rtp_dtmf_pkg.sv =====
// Types, constants and the DTMF character map for the RTP telephone-event parser.
// Depends on nothing.
package rtp_dtmf_pkg;

  localparam int unsigned CountW   = 7;
  localparam logic [CountW-1:0] CountMax = 7'd127;
  localparam logic [CountW-1:0] HdrLen   = 7'd12;
  localparam logic [1:0]  RtpVersion = 2'd2;
  localparam logic [7:0]  MaxKnownEvent = 8'h0F;
  localparam logic [7:0]  CharZero = 8'h30;
  localparam logic [7:0]  CharStar = 8'h2a;
  localparam logic [7:0]  CharHash = 8'h23;
  localparam logic [7:0]  CharA    = 8'h41;
  localparam logic [7:0]  CodeStar = 8'd10;
  localparam logic [7:0]  CodeHash = 8'd11;
  localparam logic [7:0]  CodeA    = 8'd12;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_BAD_VER = 2'd2,
    ST_UNKNOWN = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    status_e     status;
    logic [7:0]  event_code;
    logic        event_ended;
    logic [5:0]  volume;
    logic [15:0] duration;
    logic [7:0]  digit_char;
  } out_item_t;

  // Map an event code 0..15 to its ASCII keypad character.
  function automatic logic [7:0] dtmf_char(input logic [7:0] code);
    logic [7:0] ch;
    if (code < CodeStar) begin
      ch = CharZero + code;
    end else if (code == CodeStar) begin
      ch = CharStar;
    end else if (code == CodeHash) begin
      ch = CharHash;
    end else begin
      ch = CharA + (code - CodeA);
    end
    return ch;
  endfunction

endpackage

// ===== design/rtp_dtmf_event_parser.sv =====
// Top level of the RTP telephone-event (DTMF) parser: byte capture, checks,
// and a result register with one skid entry. Depends on rtp_dtmf_pkg and assert_macros.svh.
//
//   channel   direction  handshake               payload
//   in        to block   in_valid_i / in_stall_o  in_data_i  (data_byte, last_byte)
//   out       from block out_valid_o / out_stall_i out_data_o (status .. digit_char)
//
// A new byte can be accepted at every edge while in_stall_o is low.
// The result of a packet is registered, in the result register or the skid entry, when its last byte is accepted.
// Reset clears the byte counter, the captured header and event fields and the
// valid flags of both result slots. in_stall_o rises only when the result register
// and the skid entry both hold results, which needs the output stalled across two packet ends.
`include "assert_macros.svh"

module rtp_dtmf_event_parser
  import rtp_dtmf_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_data_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_data_o
);

  // Per-packet state.
  logic [CountW-1:0] byte_count_q, byte_count_d;
  logic [3:0]        csrc_count_q, csrc_count_d;
  logic              version_good_q, version_good_d;
  logic [7:0]        event_byte_q, event_byte_d;
  logic              end_bit_q, end_bit_d;
  logic [5:0]        volume_bits_q, volume_bits_d;
  logic [15:0]       duration_word_q, duration_word_d;

  // Result register and skid entry.
  logic      out_valid_q, skid_valid_q;
  out_item_t out_q, skid_q;

  logic        in_acc, out_take, res_valid;
  logic [7:0]  b;
  logic [CountW-1:0] offset;
  logic [CountW:0]   pkt_len;
  status_e     status;
  out_item_t   res;

  assign in_acc   = in_valid_i && !in_stall_o;
  assign out_take = out_valid_q && !out_stall_i;
  assign b        = in_data_i.data_byte;
  assign res_valid = in_acc && in_data_i.last_byte;

  // Capture header and event-block bytes by position in the packet.
  always_comb begin
    csrc_count_d    = csrc_count_q;
    version_good_d  = version_good_q;
    event_byte_d    = event_byte_q;
    end_bit_d       = end_bit_q;
    volume_bits_d   = volume_bits_q;
    duration_word_d = duration_word_q;

    if (byte_count_q == '0) begin
      version_good_d = (b[7:6] == RtpVersion);
      csrc_count_d   = b[3:0];
    end

    // Event block starts after the fixed header and the CSRC list.
    offset = HdrLen + {1'b0, csrc_count_d, 2'b00};

    if (byte_count_q == offset) begin
      event_byte_d = b;
    end else if (byte_count_q == offset + 7'd1) begin
      end_bit_d     = b[7];
      volume_bits_d = b[5:0];
    end else if (byte_count_q == offset + 7'd2) begin
      duration_word_d[15:8] = b;
    end else if (byte_count_q == offset + 7'd3) begin
      duration_word_d[7:0] = b;
    end

    // Saturate the counter; later bytes cannot reach the event block.
    byte_count_d = (byte_count_q < CountMax) ? byte_count_q + 7'd1 : byte_count_q;

    // Length includes the byte just taken.
    pkt_len = {1'b0, byte_count_q} + 8'd1;
    if (pkt_len < {1'b0, HdrLen}) begin
      status = ST_SHORT;
    end else if (!version_good_d) begin
      status = ST_BAD_VER;
    end else if (pkt_len < ({1'b0, offset} + 8'd4)) begin
      status = ST_SHORT;
    end else if (event_byte_d > MaxKnownEvent) begin
      status = ST_UNKNOWN;
    end else begin
      status = ST_OK;
    end

    res             = '0;
    res.status      = status;
    if (status == ST_OK || status == ST_UNKNOWN) begin
      res.event_code = event_byte_d;
    end
    if (status == ST_OK) begin
      res.event_ended = end_bit_d;
      res.volume      = volume_bits_d;
      res.duration    = duration_word_d;
      res.digit_char  = dtmf_char(event_byte_d);
    end
  end

  // Packet state: advance on every accepted byte, clear after the last one.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_count_q    <= '0;
      csrc_count_q    <= '0;
      version_good_q  <= 1'b0;
      event_byte_q    <= '0;
      end_bit_q       <= 1'b0;
      volume_bits_q   <= '0;
      duration_word_q <= '0;
    end else if (in_acc) begin
      if (in_data_i.last_byte) begin
        byte_count_q    <= '0;
        csrc_count_q    <= '0;
        version_good_q  <= 1'b0;
        event_byte_q    <= '0;
        end_bit_q       <= 1'b0;
        volume_bits_q   <= '0;
        duration_word_q <= '0;
      end else begin
        byte_count_q    <= byte_count_d;
        csrc_count_q    <= csrc_count_d;
        version_good_q  <= version_good_d;
        event_byte_q    <= event_byte_d;
        end_bit_q       <= end_bit_d;
        volume_bits_q   <= volume_bits_d;
        duration_word_q <= duration_word_d;
      end
    end
  end

  // Output valid flags. The skid entry only fills when the result register
  // is full and stalled; input is stalled while it is full, so no new result
  // can arrive while the skid drains.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else if (skid_valid_q) begin
      if (out_take) begin
        skid_valid_q <= 1'b0;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_valid_q <= 1'b1;
      end else begin
        out_valid_q <= 1'b1;
      end
    end else if (out_take) begin
      out_valid_q <= 1'b0;
    end
  end

  // Result payloads: hold while stalled, load from skid or fresh result.
  always_ff @(posedge clk_i) begin
    if (skid_valid_q) begin
      if (out_take) begin
        out_q <= skid_q;
      end
    end else if (res_valid) begin
      if (out_valid_q && !out_take) begin
        skid_q <= res;
      end else begin
        out_q <= res;
      end
    end
  end

  assign in_stall_o  = skid_valid_q;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  `CHK_IMPLY(a_skid_needs_out, skid_valid_q, out_valid_q, "skid entry full while result register empty")
  `CHK_NEXT(a_clear_after_last, in_acc && in_data_i.last_byte, byte_count_q == '0, "byte counter not cleared after last byte")
  `CHK_IMPLY(a_ok_has_char, out_valid_q && out_q.status == ST_OK, out_q.digit_char != 8'd0, "ok result without a DTMF character")

endmodule

// ===== tb/testbench.sv =====
// Testbench for the RTP telephone-event parser: streams packets byte by byte and
// compares every parse report against a predictor kept in the scoreboard class.
// Depends on rtp_dtmf_pkg and the rtp_dtmf_event_parser RTL.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import rtp_dtmf_pkg::*;

  typedef logic [7:0] pkt_q_t[$];

  localparam int unsigned ItemTarget = 1630;   // directed bytes plus about 1600 random
  localparam int unsigned CycleLimit = 100000;
  localparam int unsigned DrainCycles = 8;
  localparam int unsigned ReportLimit = 10;

  // Scoreboard: a byte-level model of the parser plus the queue of reports it
  // has predicted but not yet seen on the output channel.
  class dtmf_scoreboard;
    logic [6:0]  pkt_len;
    logic [3:0]  hdr_csrc;
    logic        hdr_ver_ok;
    logic [7:0]  ev_code;
    logic        ev_end;
    logic [5:0]  ev_vol;
    logic [15:0] ev_dur;
    out_item_t   reports_due[$];
    int unsigned failures;

    function new();
      failures = 0;
      clear_packet();
    endfunction

    function void clear_packet();
      pkt_len    = '0;
      hdr_csrc   = '0;
      hdr_ver_ok = 1'b0;
      ev_code    = '0;
      ev_end     = 1'b0;
      ev_vol     = '0;
      ev_dur     = '0;
    endfunction

    function logic [7:0] keypad_ascii(logic [7:0] code);
      if (code < CodeStar) return CharZero + code;
      if (code == CodeStar) return CharStar;
      if (code == CodeHash) return CharHash;
      return CharA + (code - CodeA);
    endfunction

    // Advance the model by one accepted byte; queue a report on the last byte.
    function void parse_byte(in_item_t it);
      int unsigned idx;
      int unsigned ofs;
      int unsigned len;
      status_e     st;
      out_item_t   rep;
      idx = pkt_len;
      if (idx == 0) begin
        hdr_ver_ok = (it.data_byte[7:6] == RtpVersion);
        hdr_csrc   = it.data_byte[3:0];
      end
      ofs = HdrLen + 4 * hdr_csrc;
      if (idx == ofs) begin
        ev_code = it.data_byte;
      end else if (idx == ofs + 1) begin
        ev_end = it.data_byte[7];
        ev_vol = it.data_byte[5:0];
      end else if (idx == ofs + 2) begin
        ev_dur[15:8] = it.data_byte;
      end else if (idx == ofs + 3) begin
        ev_dur[7:0] = it.data_byte;
      end
      if (pkt_len != CountMax) pkt_len = pkt_len + 1'b1;
      if (!it.last_byte) return;

      // Length includes the last byte; too short beats a wrong version only
      // below the fixed header.
      len = idx + 1;
      if (len < HdrLen) st = ST_SHORT;
      else if (!hdr_ver_ok) st = ST_BAD_VER;
      else if (len < ofs + 4) st = ST_SHORT;
      else if (ev_code > MaxKnownEvent) st = ST_UNKNOWN;
      else st = ST_OK;

      rep = '0;
      rep.status = st;
      if (st == ST_OK || st == ST_UNKNOWN) rep.event_code = ev_code;
      if (st == ST_OK) begin
        rep.event_ended = ev_end;
        rep.volume      = ev_vol;
        rep.duration    = ev_dur;
        rep.digit_char  = keypad_ascii(ev_code);
      end
      reports_due.push_back(rep);
      clear_packet();
    endfunction

    function void flag(string what, out_item_t exp, out_item_t got);
      failures++;
      if (failures <= ReportLimit) begin
        $display("[%0t] %s: exp st=%0d ev=%02h end=%0d vol=%0d dur=%04h ch=%02h",
                 $realtime, what, exp.status, exp.event_code, exp.event_ended,
                 exp.volume, exp.duration, exp.digit_char);
        $display("           got st=%0d ev=%02h end=%0d vol=%0d dur=%04h ch=%02h",
                 got.status, got.event_code, got.event_ended,
                 got.volume, got.duration, got.digit_char);
      end
    endfunction

    // Compare one output transaction with the oldest predicted report.
    function void check_report(out_item_t got);
      out_item_t exp;
      bit        bad;
      if (reports_due.size() == 0) begin
        flag("report with none pending", '0, got);
        return;
      end
      exp = reports_due.pop_front();
      bad = 1'b0;
      if (got.status !== exp.status) bad = 1'b1;
      if (got.event_code !== exp.event_code) bad = 1'b1;
      if (got.event_ended !== exp.event_ended) bad = 1'b1;
      if (got.volume !== exp.volume) bad = 1'b1;
      if (got.duration !== exp.duration) bad = 1'b1;
      if (got.digit_char !== exp.digit_char) bad = 1'b1;
      if (bad) flag("report mismatch", exp, got);
    endfunction
  endclass

  logic      clk_i;
  logic      rst_ni      = 1'b0;
  logic      in_valid_i  = 1'b0;
  logic      in_stall_o;
  in_item_t  in_data_i   = '0;
  logic      out_valid_o;
  logic      out_stall_i = 1'b0;
  out_item_t out_data_o;

  dtmf_scoreboard sb = new();
  int unsigned    bytes_sent = 0;
  int unsigned    cycles = 0;
  int unsigned    sender_idle_pct = 37;
  int unsigned    recv_stall_pct = 64;

  rtp_dtmf_event_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  // Watchdog: end the run if the traffic never drains.
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Output side: check every accepted report, then pick the stall for the next
  // cycle. Values read here are the ones from before this edge.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_report(out_data_o);
    out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  // Offer one byte, with random idle cycles ahead of it, and hold it until the
  // block takes it. Also switch the idle profile as the run progresses:
  // receiver slow first, then sender slow, then both at full rate.
  task automatic send_byte(input in_item_t it);
    if (bytes_sent < ItemTarget / 3) begin
      sender_idle_pct = 37;
      recv_stall_pct  = 64;
    end else if (bytes_sent < 2 * ItemTarget / 3) begin
      sender_idle_pct = 64;
      recv_stall_pct  = 37;
    end else begin
      sender_idle_pct = 0;
      recv_stall_pct  = 0;
    end
    while ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    do @(posedge clk_i); while (in_stall_o);
    sb.parse_byte(it);
    bytes_sent++;
  endtask

  task automatic send_packet(input pkt_q_t pkt);
    in_item_t it;
    foreach (pkt[i]) begin
      it.data_byte = pkt[i];
      it.last_byte = (i == pkt.size() - 1);
      send_byte(it);
    end
  endtask

  // Random packet body with the given version, CSRC count and event code
  // placed where the parser will look for them.
  function automatic void build_packet(output pkt_q_t pkt, input int unsigned len,
                                       input logic [1:0] ver, input logic [3:0] cc,
                                       input logic [7:0] code);
    int unsigned ofs;
    pkt = {};
    for (int unsigned i = 0; i < len; i++) pkt.push_back(8'($urandom));
    pkt[0] = {ver, 2'($urandom), cc};
    ofs = HdrLen + 4 * cc;
    if (ofs < len) pkt[ofs] = code;
  endfunction

  function automatic logic [1:0] wrong_version();
    logic [1:0] v;
    v = 2'($urandom_range(2));
    if (v == RtpVersion) v = 2'd3;
    return v;
  endfunction

  initial begin
    pkt_q_t      pkt;
    int unsigned pick;
    int unsigned cc;
    int unsigned blk_end;
    logic [7:0]  code;

    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // One byte, wrong version: too short wins over the version check.
    pkt = {8'h4F};
    send_packet(pkt);
    // Full header, good version, event block missing: too short.
    build_packet(pkt, 12, RtpVersion, 4'd0, 8'd0);
    send_packet(pkt);
    // Good packet with '#', end bit set and all-ones volume and duration.
    build_packet(pkt, 16, RtpVersion, 4'd0, CodeHash);
    pkt[13] = 8'hBF;
    pkt[14] = 8'hFF;
    pkt[15] = 8'hFF;
    send_packet(pkt);

    // Random traffic: mostly well-formed packets with random content, plus
    // truncated, long, wrong-version and pure noise packets.
    while (bytes_sent < ItemTarget) begin
      pick = $urandom_range(99);
      cc = ($urandom_range(9) == 0) ? $urandom_range(15) : $urandom_range(2);
      blk_end = HdrLen + 4 * cc + 4;
      code = ($urandom_range(9) == 0) ? 8'($urandom_range(255, 16)) : 8'($urandom_range(15));
      if (pick < 70) begin
        build_packet(pkt, blk_end + $urandom_range(6), RtpVersion, 4'(cc), code);
      end else if (pick < 78) begin
        // Run the byte counter into saturation.
        build_packet(pkt, $urandom_range(150, 128), RtpVersion, 4'($urandom_range(15)), code);
      end else if (pick < 88) begin
        build_packet(pkt, $urandom_range(blk_end - 1, 1), RtpVersion, 4'(cc), code);
      end else if (pick < 95) begin
        build_packet(pkt, $urandom_range(blk_end + 4, 12), wrong_version(), 4'(cc), code);
      end else begin
        build_packet(pkt, $urandom_range(40, 1), 2'($urandom), 4'($urandom), 8'($urandom));
      end
      send_packet(pkt);
    end
    in_valid_i <= 1'b0;

    // Drain: wait for every predicted report, then keep waiting for strays.
    while (sb.reports_due.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (sb.reports_due.size() != 0) sb.failures++;

    if (sb.failures == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== rtp_dtmf_event_parser.f =====
+incdir+design
design/rtp_dtmf_pkg.sv
design/rtp_dtmf_event_parser.sv
tb/testbench.sv
